// ===== design/ppm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the point pair metric unit.
// No dependencies; the top level and the checker refer to it by scoped names.
package ppm_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int COORD_FRAC  = 8;
    localparam int VALUE_WIDTH = 40;

    localparam logic [2:0] KIND_SLOPE     = 3'd0;
    localparam logic [2:0] KIND_X_DIST    = 3'd1;
    localparam logic [2:0] KIND_Y_DIST    = 3'd2;
    localparam logic [2:0] KIND_MANHATTAN = 3'd3;
    localparam logic [2:0] KIND_EUCLID    = 3'd4;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIV_ZERO = 1'b1;

    typedef struct packed {
        logic [2:0]                    kind;
        logic signed [COORD_WIDTH-1:0] first_x;
        logic signed [COORD_WIDTH-1:0] first_y;
        logic signed [COORD_WIDTH-1:0] second_x;
        logic signed [COORD_WIDTH-1:0] second_y;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] metric_value;
        logic                          status;
    } t_out_item;

endpackage

// ===== design/point_pair_metric_unit.sv =====
`timescale 1ns / 1ps
// Top level of the point pair metric unit: front end, step pipeline, output.
// Depends on ppm_pkg and ppm_step.
//
// Usage:
//   Input channel (i_valid / o_stall / i_item): two points in signed Q8.8 and
//   a kind code (slope, x distance, y distance, manhattan, euclidean). An item
//   is taken at a rising edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall / o_item): one result per item, a
//   40-bit signed value with RESULT_FRAC_BITS fraction bits and a status bit
//   that flags a slope with zero dx (value zero then). Kinds 5 to 7 give 0.
//   Throughput: one item per cycle while the receiver does not stall. The
//   pipeline depth is set by the restoring divider and square root, which
//   both resolve one result bit per stage of the shared step pipeline.
//   Stages: difference/magnitude, squaring, operand setup, one stage per
//   quotient bit, then saturate into the output register.
//   Reset (synchronous, active low) clears every stage valid bit; no payload
//   is cleared. While the receiver stalls a full output register, the whole
//   pipeline holds and o_stall is raised; nothing is dropped or repeated.
module point_pair_metric_unit #(
    parameter int RESULT_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ppm_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output ppm_pkg::t_out_item  o_item
);

    localparam int CW   = ppm_pkg::COORD_WIDTH;
    localparam int VW   = ppm_pkg::VALUE_WIDTH;
    localparam int LIFT = RESULT_FRAC_BITS - ppm_pkg::COORD_FRAC;
    localparam int AW   = CW + 1;                 // magnitude of a difference
    localparam int QW   = AW + RESULT_FRAC_BITS;  // quotient and root width
    localparam int MW   = QW + 1;                 // widest metric magnitude
    localparam int XW   = (MW > VW + 1) ? MW : VW + 1;
    localparam logic [XW-1:0] POS_MAX = {{(XW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic [XW-1:0] NEG_MAG = {{(XW-VW){1'b0}}, 1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic [2:0]    kind;
        logic          neg;
        logic          dxz;
        logic [AW-1:0] ax;
        logic [AW-1:0] ay;
    } t_front;

    typedef struct packed {
        logic [2:0]      kind;
        logic            neg;
        logic            dxz;
        logic [AW-1:0]   ax;
        logic [AW-1:0]   ay;
        logic [AW-1:0]   div_rem;
        logic [QW-1:0]   div_num;
        logic [QW-1:0]   div_quo;
        logic [QW:0]     sq_rem;
        logic [2*QW-1:0] sq_rad;
        logic [QW-1:0]   sq_root;
    } t_lane;

    // whole pipeline moves unless a finished result waits on a stalled receiver
    logic adv;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;

    // ---- stage 1: differences and magnitudes
    logic signed [AW-1:0] dx;
    logic signed [AW-1:0] dy;
    t_front               n_s1;
    t_front               r_s1;
    logic                 r_s1_vld;

    always_comb begin
        dx = $signed({i_item.second_x[CW-1], i_item.second_x})
           - $signed({i_item.first_x[CW-1], i_item.first_x});
        dy = $signed({i_item.second_y[CW-1], i_item.second_y})
           - $signed({i_item.first_y[CW-1], i_item.first_y});
        n_s1.kind = i_item.kind;
        n_s1.neg  = dx[AW-1] ^ dy[AW-1];
        n_s1.dxz  = (dx == '0);
        n_s1.ax   = dx[AW-1] ? AW'(-dx) : AW'(dx);
        n_s1.ay   = dy[AW-1] ? AW'(-dy) : AW'(dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_valid;
        end
        if (adv) begin
            r_s1 <= n_s1;
        end
    end

    // ---- stage 2: squares for the euclidean distance
    t_front          r_s2;
    logic            r_s2_vld;
    logic [2*AW-1:0] r_sqx;
    logic [2*AW-1:0] r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld;
        end
        if (adv) begin
            r_s2  <= r_s1;
            r_sqx <= r_s1.ax * r_s1.ax;
            r_sqy <= r_s1.ay * r_s1.ay;
        end
    end

    // ---- stage 3: load divider and square root operands
    logic [2*AW:0] sq_sum;
    t_lane         n_lane [QW+1];
    t_lane         r_lane [QW+1];
    logic          r_lane_vld [QW+1];

    always_comb begin
        sq_sum            = {1'b0, r_sqx} + {1'b0, r_sqy};
        n_lane[0].kind    = r_s2.kind;
        n_lane[0].neg     = r_s2.neg;
        n_lane[0].dxz     = r_s2.dxz;
        n_lane[0].ax      = r_s2.ax;
        n_lane[0].ay      = r_s2.ay;
        n_lane[0].div_rem = '0;
        n_lane[0].div_num = {r_s2.ay, {RESULT_FRAC_BITS{1'b0}}};
        n_lane[0].div_quo = '0;
        n_lane[0].sq_rem  = '0;
        n_lane[0].sq_rad  = (2*QW)'(sq_sum) << (2 * LIFT);
        n_lane[0].sq_root = '0;
    end

    // ---- stages 4 .. QW+3: one quotient bit and one root bit per stage
    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_step
            ppm_step #(
                .AW (AW),
                .QW (QW)
            ) u_step (
                .i_div_rem (r_lane[k].div_rem),
                .i_div_num (r_lane[k].div_num),
                .i_div_quo (r_lane[k].div_quo),
                .i_divisor (r_lane[k].ax),
                .i_sq_rem  (r_lane[k].sq_rem),
                .i_sq_rad  (r_lane[k].sq_rad),
                .i_sq_root (r_lane[k].sq_root),
                .o_div_rem (n_lane[k+1].div_rem),
                .o_div_num (n_lane[k+1].div_num),
                .o_div_quo (n_lane[k+1].div_quo),
                .o_sq_rem  (n_lane[k+1].sq_rem),
                .o_sq_rad  (n_lane[k+1].sq_rad),
                .o_sq_root (n_lane[k+1].sq_root)
            );
            assign n_lane[k+1].kind = r_lane[k].kind;
            assign n_lane[k+1].neg  = r_lane[k].neg;
            assign n_lane[k+1].dxz  = r_lane[k].dxz;
            assign n_lane[k+1].ax   = r_lane[k].ax;
            assign n_lane[k+1].ay   = r_lane[k].ay;
        end

        for (k = 0; k <= QW; k++) begin : g_lane_reg
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_lane_vld[k] <= 1'b0;
                end else if (adv) begin
                    r_lane_vld[k] <= (k == 0) ? r_s2_vld : r_lane_vld[(k == 0) ? 0 : k-1];
                end
                if (adv) begin
                    r_lane[k] <= n_lane[k];
                end
            end
        end
    endgenerate

    // ---- output stage: select the metric, saturate, sign
    t_lane              last;
    logic [MW-1:0]      mag;
    logic [XW-1:0]      mag_x;
    logic [XW-1:0]      neg_x;
    logic               neg_o;
    logic               stat;
    ppm_pkg::t_out_item n_out;
    ppm_pkg::t_out_item r_out;
    logic               r_out_vld;

    always_comb begin
        last  = r_lane[QW];
        mag   = '0;
        neg_o = 1'b0;
        stat  = ppm_pkg::STATUS_OK;
        case (last.kind)
            ppm_pkg::KIND_SLOPE: begin
                if (last.dxz) begin
                    stat = ppm_pkg::STATUS_DIV_ZERO;
                end else begin
                    mag   = MW'(last.div_quo);
                    neg_o = last.neg;
                end
            end
            ppm_pkg::KIND_X_DIST:    mag = MW'(last.ax) << LIFT;
            ppm_pkg::KIND_Y_DIST:    mag = MW'(last.ay) << LIFT;
            ppm_pkg::KIND_MANHATTAN: mag = (MW'(last.ax) + MW'(last.ay)) << LIFT;
            ppm_pkg::KIND_EUCLID:    mag = MW'(last.sq_root);
            default:                 mag = '0;
        endcase

        mag_x = XW'(mag);
        if (neg_o) begin
            neg_x = (mag_x > NEG_MAG) ? NEG_MAG : mag_x;
            neg_x = XW'(0) - neg_x;
        end else begin
            neg_x = (mag_x > POS_MAX) ? POS_MAX : mag_x;
        end
        n_out.metric_value = neg_x[VW-1:0];
        n_out.status       = stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_lane_vld[QW];
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule

// ===== design/ppm_step.sv =====
`timescale 1ns / 1ps
// One combined step: a restoring division bit and a square root bit.
// Stand-alone; instantiated once per step stage by the top level.
module ppm_step #(
    parameter int AW = 17,
    parameter int QW = 33
) (
    input  logic [AW-1:0]   i_div_rem,
    input  logic [QW-1:0]   i_div_num,
    input  logic [QW-1:0]   i_div_quo,
    input  logic [AW-1:0]   i_divisor,
    input  logic [QW:0]     i_sq_rem,
    input  logic [2*QW-1:0] i_sq_rad,
    input  logic [QW-1:0]   i_sq_root,
    output logic [AW-1:0]   o_div_rem,
    output logic [QW-1:0]   o_div_num,
    output logic [QW-1:0]   o_div_quo,
    output logic [QW:0]     o_sq_rem,
    output logic [2*QW-1:0] o_sq_rad,
    output logic [QW-1:0]   o_sq_root
);

    logic [AW:0]   div_part;
    logic [AW:0]   div_diff;
    logic [QW+2:0] sq_part;
    logic [QW+2:0] sq_trial;
    logic [QW+2:0] sq_diff;

    always_comb begin
        // bring down the next numerator bit
        div_part  = {i_div_rem, i_div_num[QW-1]};
        div_diff  = div_part - {1'b0, i_divisor};
        o_div_num = {i_div_num[QW-2:0], 1'b0};
        if (div_part >= {1'b0, i_divisor}) begin
            o_div_rem = div_diff[AW-1:0];
            o_div_quo = {i_div_quo[QW-2:0], 1'b1};
        end else begin
            o_div_rem = div_part[AW-1:0];
            o_div_quo = {i_div_quo[QW-2:0], 1'b0};
        end

        // bring down the next radicand bit pair
        sq_part  = {i_sq_rem, i_sq_rad[2*QW-1 -: 2]};
        sq_trial = {1'b0, i_sq_root, 2'b01};
        sq_diff  = sq_part - sq_trial;
        o_sq_rad = {i_sq_rad[2*QW-3:0], 2'b00};
        if (sq_part >= sq_trial) begin
            o_sq_rem  = sq_diff[QW:0];
            o_sq_root = {i_sq_root[QW-2:0], 1'b1};
        end else begin
            o_sq_rem  = sq_part[QW:0];
            o_sq_root = {i_sq_root[QW-2:0], 1'b0};
        end
    end

endmodule

// ===== design/ppm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the point pair metric unit, bound to the top level.
// Depends on ppm_pkg.
module ppm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input ppm_pkg::t_in_item  i_item,
    input logic               o_valid,
    input logic               i_stall,
    input ppm_pkg::t_out_item o_item
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // input is pushed back only by a stalled full output
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    // zero divisor always reports a zero value
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.status == ppm_pkg::STATUS_DIV_ZERO |-> o_item.metric_value == '0)
        else $error("division status with nonzero value");

    // no result right after reset releases
    a_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) && $past(i_rst_n, 2) == 1'b0 |-> !o_valid)
        else $error("result valid straight out of reset");

endmodule

bind point_pair_metric_unit ppm_checker u_ppm_checker (.*);
